>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/b32m_pkg.sv
// Types and constants for the binary32 multiplier.
// Depends on nothing.
package b32m_pkg;
  localparam logic [31:0] SignMask   = 32'h8000_0000;
  localparam logic [31:0] InfBits    = 32'h7f80_0000;
  localparam logic [31:0] DefaultNan = 32'hffc0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [9:0]  ExpBias    = 10'd127;
  localparam logic [9:0]  MaxNormExp = 10'd254;
  localparam logic [4:0]  ShiftCap   = 5'd25;

  // Unpacked operand word after normalisation.
  typedef struct packed {
    logic [23:0] mant;
    logic [9:0]  expo;  // signed, two's complement
  } unp_t;

  // Count leading zeros of a 23-bit fraction (fraction nonzero).
  function automatic logic [4:0] lzc23(input logic [22:0] f);
    logic [4:0] n;
    n = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) n = 5'(22 - i);
    end
    return n;
  endfunction
endpackage

>>> sv/b32m_unpack.sv
// Operand unpacking: normalises subnormal significands.
// Depends on b32m_pkg.
module b32m_unpack (
  input  logic [31:0]         word_i,
  output b32m_pkg::unp_t      unp_o
);
  import b32m_pkg::*;
  logic [4:0] lz;
  assign lz = lzc23(word_i[22:0]);
  always_comb begin
    if (word_i[30:23] != 8'd0) begin
      unp_o.mant = {1'b1, word_i[22:0]};
      unp_o.expo = {2'b00, word_i[30:23]};
    end else begin
      // shift the leading one up to the hidden position
      unp_o.mant = 24'({1'b0, word_i[22:0]} << (lz + 5'd1));
      unp_o.expo = 10'd1 - 10'(lz) - 10'd1;
    end
  end
endmodule

>>> sv/b32m_round.sv
// Significand product, exponent adjust, denormalisation, rounding and special values.
// Depends on b32m_pkg.
module b32m_round (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] prod_o
);
  import b32m_pkg::*;
  unp_t ua, ub;
  logic [47:0] prod, pn;
  logic [9:0]  e;
  logic [31:0] sign, r;
  logic [30:0] mag_a, mag_b;
  logic [5:0]  shift;
  logic [48:0] ext, mant, rem, half, mask;

  b32m_unpack u_ua (.word_i(a_i), .unp_o(ua));
  b32m_unpack u_ub (.word_i(b_i), .unp_o(ub));

  assign mag_a = a_i[30:0];
  assign mag_b = b_i[30:0];
  assign sign  = (a_i ^ b_i) & SignMask;
  assign prod  = ua.mant * ub.mant;

  always_comb begin
    e = ua.expo + ub.expo - ExpBias;
    if (prod[47]) begin
      e  = e + 10'd1;
      pn = prod;
    end else begin
      pn = prod << 1;
    end
    shift = 6'd0;
    r     = 32'd0;
    mask  = '0;
    ext   = {1'b0, pn};
    if ($signed(e) >= 10'sd1) begin
      mant = ext >> 24;
      rem  = ext & 49'hff_ffff;
      half = 49'h80_0000;
      r = sign + {e[7:0] - 8'd1, 23'd0} + mant[31:0];
    end else begin
      if ($signed(10'd1 - e) > $signed({5'd0, ShiftCap})) shift = 6'(ShiftCap);
      else shift = 6'(10'd1 - e);
      mant = ext >> (6'd24 + shift);
      mask = (49'd1 << (6'd24 + shift)) - 49'd1;
      rem  = ext & mask;
      half = 49'd1 << (6'd23 + shift);
      r = sign | mant[31:0];
    end
    if (rem > half || (rem == half && mant[0])) r = r + 32'd1;

    if (mag_a > InfBits[30:0])      prod_o = a_i | QuietBit;
    else if (mag_b > InfBits[30:0]) prod_o = b_i | QuietBit;
    else if (mag_a == InfBits[30:0] || mag_b == InfBits[30:0]) begin
      if (mag_a == 31'd0 || mag_b == 31'd0) prod_o = DefaultNan;
      else prod_o = sign | InfBits;
    end
    else if (mag_a == 31'd0 || mag_b == 31'd0) prod_o = sign;
    else if ($signed(e) > $signed(MaxNormExp)) prod_o = sign | InfBits;
    else prod_o = r;
  end
endmodule

>>> sv/binary32_multiplier.sv
// binary32 multiplier, round to nearest even, one operand pair per cycle when not stalled.
// Operands register, then result register; the 24x24 significand
// multiply and rounding sit between them. An item is taken every cycle
// unless both registers hold words and the result word is held off by the
// receiver.
module binary32_multiplier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] product_o
);
  import b32m_pkg::*;
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] a_q, b_q, res;
  logic        adv2, adv1;

  // advance stage 2 when its slot is free or being taken
  assign adv2 = !out_valid_o || !out_stall_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;
  assign s1_valid_d = adv1 ? in_valid_i : s1_valid_q;

  b32m_round u_round (.a_i(a_q), .b_i(b_q), .prod_o(res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (adv2) out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
    end
    if (adv2 && s1_valid_q) product_o <= res;
  end
endmodule

>>> sv/b32m_checker.sv
// Port-level checks for the binary32 multiplier, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module b32m_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] product_o
);
  // a held result keeps its word
  `ASSERT_NEXT(held_word, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(product_o))
  // a free output never stalls the input
  `ASSERT_IMPLY(no_stall_free, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  // input stalls only behind a stalled output
  `ASSERT_IMPLY(stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // an accepted word passes the operand registers and emerges when the output is free
  `ASSERT_IMPLY(latency, clk_i, rst_ni,
    in_valid_i && !in_stall_o ##1 !(out_valid_o && out_stall_i), ##1 out_valid_o)
endmodule

bind binary32_multiplier b32m_checker u_b32m_checker (.*);
